@@ rtl/jpd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types, gain tables and saturation helpers of the joint PD controller.
package jpd_pkg;

  localparam int NUM_JOINTS_DEF = 7;

  localparam int JOINT_W    = 3;
  localparam int RATE_W     = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ANG_W      = 32;
  localparam int ACC_W      = 40;
  localparam int TORQ_W     = 25;

  localparam int DIFF_W = ANG_W + 1;        // difference of two Q16.16 values
  localparam int MA_W   = 42;               // multiplier operand a, holds net
  localparam int MB_W   = 18;               // multiplier operand b, signed
  localparam int PROD_W = MA_W + MB_W;
  localparam int SUM_W  = 50;               // acc + kd term + kp term
  localparam int NET_W  = 42;               // net saturated to +-2^40
  localparam int SHR_W  = PROD_W - 16;      // product after the Q.16 shift
  localparam int INER_W = 17;
  localparam int KD_W   = 8;
  localparam int KP_W   = 14;

  localparam logic signed [SUM_W-1:0] NET_HI = 50'sd1099511627776;
  localparam logic signed [SUM_W-1:0] NET_LO = -50'sd1099511627776;

  localparam logic [MODE_W-1:0] MODE_OP  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SIM = 2'd1;

  localparam logic [RATE_W-1:0] RATE_RST = 16'd1000;
  localparam logic [MODE_W-1:0] MODE_RST = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE = 2'd0,
    CFG_MODE = 2'd1,
    CFG_EXEC = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_VEL,
    S_SATV,
    S_ACC,
    S_KD,
    S_KP,
    S_NET,
    S_TQ,
    S_CLP
  } ctl_state_t;

  // Joint inertia, unsigned Q0.16
  function automatic logic [INER_W-1:0] inertia_of(input logic [JOINT_W-1:0] j);
    logic [INER_W-1:0] r;
    case (j)
      3'd0, 3'd1: r = 17'd49152;
      3'd2, 3'd3: r = 17'd13926;
      default:    r = 17'd3768;
    endcase
    return r;
  endfunction

  // Torque limit already scaled to Q9.16
  function automatic logic [TORQ_W-1:0] tmax_of(input logic [JOINT_W-1:0] j);
    logic [TORQ_W-1:0] r;
    case (j)
      3'd0, 3'd1: r = 25'd13107200;
      3'd2, 3'd3: r = 25'd5242880;
      3'd4, 3'd5: r = 25'd983040;
      default:    r = 25'd655360;
    endcase
    return r;
  endfunction

  function automatic logic [KD_W-1:0] kd_of(input logic [JOINT_W-1:0] j);
    logic [KD_W-1:0] r;
    case (j)
      3'd0, 3'd1: r = 8'd123;
      3'd2, 3'd3: r = 8'd104;
      3'd4:       r = 8'd70;
      default:    r = 8'd91;
    endcase
    return r;
  endfunction

  function automatic logic [KP_W-1:0] kp_of(input logic [JOINT_W-1:0] j);
    logic [KP_W-1:0] r;
    case (j)
      3'd0:             r = 14'd10500;
      3'd1:             r = 14'd9000;
      3'd2, 3'd3:       r = 14'd7000;
      3'd4, 3'd5:       r = 14'd5000;
      default:          r = 14'd4900;
    endcase
    return r;
  endfunction

  function automatic logic signed [ANG_W-1:0] sat_vel(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-ANG_W:0] top;
    logic signed [ANG_W-1:0] r;
    top = v[PROD_W-1:ANG_W-1];
    if ((&top) || !(|top)) r = v[ANG_W-1:0];
    else if (v[PROD_W-1])  r = {1'b1, {(ANG_W-1){1'b0}}};
    else                   r = {1'b0, {(ANG_W-1){1'b1}}};
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-ACC_W:0] top;
    logic signed [ACC_W-1:0] r;
    top = v[PROD_W-1:ACC_W-1];
    if ((&top) || !(|top)) r = v[ACC_W-1:0];
    else if (v[PROD_W-1])  r = {1'b1, {(ACC_W-1){1'b0}}};
    else                   r = {1'b0, {(ACC_W-1){1'b1}}};
    return r;
  endfunction

  function automatic logic signed [NET_W-1:0] sat_net(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if (v > NET_HI)      r = NET_HI;
    else if (v < NET_LO) r = NET_LO;
    else                 r = v;
    return NET_W'(r);
  endfunction

  // Round to nearest (floor of x + 1/2), drop 16 fraction bits, clamp to +-tmax
  function automatic logic signed [TORQ_W-1:0] clamp_torq(
    input logic signed [PROD_W-1:0] p,
    input logic [TORQ_W-1:0]        tmax
  );
    logic signed [PROD_W-1:0] rnd;
    logic signed [SHR_W-1:0]  sh;
    logic signed [SHR_W-1:0]  lim;
    logic signed [TORQ_W-1:0] r;
    rnd = p + PROD_W'(32768);
    sh  = rnd[PROD_W-1:16];
    lim = $signed(SHR_W'(tmax));
    if (sh > lim)       r = $signed(tmax);
    else if (sh < -lim) r = -$signed(tmax);
    else                r = sh[TORQ_W-1:0];
    return r;
  endfunction

endpackage

@@ rtl/jpd_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces: joint sample in, controller result out, register write.
interface jpd_sample_if
  import jpd_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [JOINT_W-1:0]      joint_index;
  logic signed [ANG_W-1:0] target_angle;
  logic signed [ANG_W-1:0] measured_angle;
  logic signed [ANG_W-1:0] measured_velocity;

  modport source (output valid, joint_index, target_angle, measured_angle,
                  measured_velocity, input ready);
  modport sink   (input valid, joint_index, target_angle, measured_angle,
                  measured_velocity, output ready);
endinterface

interface jpd_result_if
  import jpd_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [JOINT_W-1:0]       out_joint;
  logic signed [TORQ_W-1:0] torque_command;
  logic                     drive_enable;
  logic                     drive_write;
  logic signed [ANG_W-1:0]  desired_velocity;
  logic signed [ACC_W-1:0]  desired_acceleration;
  logic signed [ANG_W-1:0]  position_echo;
  logic                     echo_valid;

  modport source (output valid, out_joint, torque_command, drive_enable, drive_write,
                  desired_velocity, desired_acceleration, position_echo, echo_valid,
                  input ready);
  modport sink   (input valid, out_joint, torque_command, drive_enable, drive_write,
                  desired_velocity, desired_acceleration, position_echo, echo_valid,
                  output ready);
endinterface

interface jpd_cfg_if
  import jpd_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/joint_pd_torque_controller.sv @@
`timescale 1ns / 1ps
// Joint PD torque controller with acceleration feed-forward, one shared multiplier.
//
// Usage:
//  - sample: one transaction per joint sample (joint index, target, measured angle
//    and velocity). Ready is high only while the sequencer is idle.
//  - result: one transaction per in-range sample, held in an output register until
//    the receiver takes it. A new sample is accepted while a result still waits;
//    that sample stalls only in its last step if the old result is still unread.
//  - cfg: register writes (0 sample rate, 1 control mode, 2 execute enable),
//    always ready, to be issued only while no sample is in flight.
//  - Flow: a sample passes the states VEL, SATV, ACC, KD, KP, NET, TQ and CLP, and the
//    result register loads in CLP. A new sample is taken only once the sequencer is back
//    in idle. Five multiplies (velocity, acceleration, D term, P term, inertia) go through
//    one 42x18 multiplier, each followed by a register.
//  - A sample with a joint index at or above NUM_JOINTS is accepted and dropped:
//    no result, no state change, ready stays high.
//  - Reset: registers go to 1000 Hz, mode "other", execute off; every joint is
//    marked unprimed, so its first sample gives zero velocity and acceleration.
module joint_pd_torque_controller
  import jpd_pkg::*;
#(
  parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  jpd_cfg_if.sink      cfg,
  jpd_sample_if.sink   sample,
  jpd_result_if.source result
);

  localparam int JIDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  // configuration registers
  logic [RATE_W-1:0] rate;
  logic [MODE_W-1:0] mode;
  logic              exec;

  // per-joint history
  logic signed [ANG_W-1:0] prev_tgt [NUM_JOINTS];
  logic signed [ANG_W-1:0] prev_vel [NUM_JOINTS];
  logic [NUM_JOINTS-1:0]   primed;

  // sequencer
  ctl_state_t state, state_next;
  logic       accept;
  logic       in_range;
  logic       out_load;
  logic [JIDX_W-1:0] rd_idx;

  // working registers
  logic [JOINT_W-1:0]      joint;
  logic [JIDX_W-1:0]       jidx;
  logic signed [ANG_W-1:0] tgt, meas, mvel, pt, pv, vel;
  logic signed [ACC_W-1:0] acc;
  logic signed [SUM_W-1:0] sum;
  logic signed [NET_W-1:0] net;
  logic signed [PROD_W-1:0] prod;

  // shared subtract + multiply
  logic signed [ANG_W-1:0]  diff_x, diff_y;
  logic signed [DIFF_W-1:0] diff;
  logic                     use_net;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;

  // output register
  logic                     out_valid;
  logic [JOINT_W-1:0]       o_joint;
  logic signed [TORQ_W-1:0] o_torq;
  logic                     o_drive, o_write, o_echo_vld;
  logic signed [ANG_W-1:0]  o_vel, o_echo;
  logic signed [ACC_W-1:0]  o_acc;
  logic                     drive, sim;

  assign cfg.ready    = 1'b1;
  assign sample.ready = (state == S_IDLE);
  assign accept       = sample.valid && sample.ready;
  assign in_range     = 32'(sample.joint_index) < NUM_JOINTS;
  assign rd_idx       = JIDX_W'(sample.joint_index);
  assign out_load     = (state == S_CLP) && (!out_valid || result.ready);

  assign drive = (mode == MODE_OP) && exec;
  assign sim   = (mode == MODE_SIM);

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RATE_RST;
      mode <= MODE_RST;
      exec <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        CFG_RATE: rate <= cfg.data[RATE_W-1:0];
        CFG_MODE: mode <= cfg.data[MODE_W-1:0];
        CFG_EXEC: exec <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept && in_range) state_next = S_VEL;
      S_VEL:  state_next = S_SATV;
      S_SATV: state_next = S_ACC;
      S_ACC:  state_next = S_KD;
      S_KD:   state_next = S_KP;
      S_KP:   state_next = S_NET;
      S_NET:  state_next = S_TQ;
      S_TQ:   state_next = S_CLP;
      S_CLP:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // operand select for the shared unit
  always_comb begin
    diff_x  = tgt;
    diff_y  = pt;
    use_net = 1'b0;
    mul_b   = $signed({2'b00, rate});
    case (state)
      S_VEL: begin
        diff_x = tgt;
        diff_y = pt;
      end
      S_ACC: begin
        diff_x = vel;
        diff_y = pv;
      end
      S_KD: begin
        diff_x = vel;
        diff_y = mvel;
        mul_b  = $signed(MB_W'(kd_of(joint)));
      end
      S_KP: begin
        diff_x = tgt;
        diff_y = meas;
        mul_b  = $signed(MB_W'(kp_of(joint)));
      end
      S_TQ: begin
        use_net = 1'b1;
        mul_b   = $signed(MB_W'(inertia_of(joint)));
      end
      default: ;
    endcase
  end

  assign diff  = DIFF_W'(diff_x) - DIFF_W'(diff_y);
  assign mul_a = use_net ? net : MA_W'(diff);
  assign mul_p = mul_a * mul_b;

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      joint <= sample.joint_index;
      jidx  <= rd_idx;
      tgt   <= sample.target_angle;
      meas  <= sample.measured_angle;
      mvel  <= sample.measured_velocity;
      if (primed[rd_idx]) begin
        pt <= prev_tgt[rd_idx];
        pv <= prev_vel[rd_idx];
      end else begin
        // first sample: no motion assumed
        pt <= sample.target_angle;
        pv <= '0;
      end
    end
    case (state)
      S_VEL:  prod <= mul_p;
      S_SATV: begin
        vel            <= sat_vel(prod);
        prev_tgt[jidx] <= tgt;
        prev_vel[jidx] <= sat_vel(prod);
      end
      S_ACC:  prod <= mul_p;
      S_KD: begin
        acc  <= sat_acc(prod);
        prod <= mul_p;
      end
      S_KP: begin
        sum  <= SUM_W'(acc) + SUM_W'(prod);
        prod <= mul_p;
      end
      S_NET:  net  <= sat_net(sum + SUM_W'(prod));
      S_TQ:   prod <= mul_p;
      default: ;
    endcase
    if (out_load) begin
      o_joint    <= joint;
      o_torq     <= drive ? clamp_torq(prod, tmax_of(joint)) : '0;
      o_drive    <= drive;
      o_write    <= exec;
      o_vel      <= vel;
      o_acc      <= acc;
      o_echo     <= sim ? tgt : '0;
      o_echo_vld <= sim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= '0;
    end else if (state == S_SATV) begin
      primed[jidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid                = out_valid;
  assign result.out_joint            = o_joint;
  assign result.torque_command       = o_torq;
  assign result.drive_enable         = o_drive;
  assign result.drive_write          = o_write;
  assign result.desired_velocity     = o_vel;
  assign result.desired_acceleration = o_acc;
  assign result.position_echo        = o_echo;
  assign result.echo_valid           = o_echo_vld;

endmodule

@@ tb/sv/joint_pd_torque_controller_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the joint PD torque controller: directed table, then random phases.
module joint_pd_torque_controller_tb;
  import jpd_pkg::*;

  localparam int JOINTS = 7;
  localparam logic [JOINT_W-1:0] NO_JOINT = 3'd7;   // index the block drops

  // control_mode codes the package leaves unnamed
  localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam longint VEL_MIN = -(longint'(1) <<< 31);
  localparam longint VEL_MAX = (longint'(1) <<< 31) - 1;
  localparam longint ACC_MIN = -(longint'(1) <<< 39);
  localparam longint ACC_MAX = (longint'(1) <<< 39) - 1;
  localparam longint NET_LIM = longint'(1) <<< 40;

  // Per-joint controller constants: gains are integers, inertia is Q0.16,
  // torque limit in whole N*m.
  localparam longint KP_TBL [JOINTS]      = '{10500, 9000, 7000, 7000, 5000, 5000, 4900};
  localparam longint KD_TBL [JOINTS]      = '{123, 123, 104, 104, 70, 91, 91};
  localparam longint INERTIA_TBL [JOINTS] = '{49152, 49152, 13926, 13926, 3768, 3768, 3768};
  localparam longint TMAX_TBL [JOINTS]    = '{200, 200, 80, 80, 15, 15, 10};

  // Settling margin waited after the expectation queue drains, before register writes.
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic [JOINT_W-1:0]       joint;
    logic signed [TORQ_W-1:0] torque;
    logic                     drive_en;
    logic                     drive_wr;
    logic signed [ANG_W-1:0]  vel;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ANG_W-1:0]  echo;
    logic                     echo_ok;
  } joint_cmd_t;

  typedef struct packed {
    logic [JOINT_W-1:0]      joint;
    logic signed [ANG_W-1:0] tgt;
    logic signed [ANG_W-1:0] meas;
    logic signed [ANG_W-1:0] mvel;
  } joint_sample_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    joint_sample_t         s;
    joint_cmd_t            want;
    cfg_reg_t              reg_sel;
    logic [CFG_DATA_W-1:0] data;
  } stim_row_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_SLOW} sink_style_t;

  logic clk;
  logic rst;

  jpd_cfg_if    cfg_ch ();
  jpd_sample_if smp ();
  jpd_result_if res ();

  joint_pd_torque_controller dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (smp),
    .result (res)
  );

  // Predictor copy of the register file and the per-joint history
  logic [RATE_W-1:0] rate_hz;
  logic [MODE_W-1:0] ctl_mode;
  logic              exec_on;
  longint            last_setpoint [JOINTS];
  longint            last_vel_cmd [JOINTS];
  bit                joint_seen [JOINTS];

  joint_cmd_t cmd_expected_q [$];
  stim_row_t  directed_rows [$];
  int         mismatch_count = 0;

  // Stimulus side: running trajectory per joint, so most samples are smooth
  logic signed [ANG_W-1:0] trajectory_pos [JOINTS];
  int          burst_left = 0;
  bit          hold_req = 1'b0;
  sink_style_t sink_style = SINK_OPEN;

  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop; the slowest legal run is far below this
  initial begin : watchdog
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Finite-difference velocity/acceleration, PD sum, inertia scaling and clamp.
  // Updates the joint history as the block does.
  function automatic joint_cmd_t predict_joint_command(input joint_sample_t s);
    joint_cmd_t c;
    longint     tgt, rate, vel, acc, net, torq, tlim;
    tgt  = longint'(s.tgt);
    rate = longint'({48'd0, rate_hz});
    // first sample of a joint starts from rest at its own target
    if (!joint_seen[s.joint]) begin
      last_setpoint[s.joint] = tgt;
      last_vel_cmd[s.joint]  = 0;
      joint_seen[s.joint]    = 1'b1;
    end
    vel = clip((tgt - last_setpoint[s.joint]) * rate, VEL_MIN, VEL_MAX);
    acc = clip((vel - last_vel_cmd[s.joint]) * rate, ACC_MIN, ACC_MAX);
    last_setpoint[s.joint] = tgt;
    last_vel_cmd[s.joint]  = vel;
    net = acc + KD_TBL[s.joint] * (vel - longint'(s.mvel))
              + KP_TBL[s.joint] * (tgt - longint'(s.meas));
    net  = clip(net, -NET_LIM, NET_LIM);
    torq = (net * INERTIA_TBL[s.joint] + 32768) >>> 16;   // round half up
    tlim = TMAX_TBL[s.joint] * 65536;
    torq = clip(torq, -tlim, tlim);
    c.joint    = s.joint;
    c.drive_en = (ctl_mode == MODE_OP) && exec_on;
    c.drive_wr = exec_on;
    c.torque   = c.drive_en ? TORQ_W'(torq) : '0;
    c.vel      = ANG_W'(vel);
    c.acc      = ACC_W'(acc);
    c.echo_ok  = (ctl_mode == MODE_SIM);
    c.echo     = c.echo_ok ? s.tgt : '0;
    return c;
  endfunction

  function automatic joint_cmd_t make_cmd(input logic [JOINT_W-1:0] j, input longint torque,
                                          input bit de, input bit dw, input longint vel,
                                          input longint acc, input longint echo, input bit ev);
    joint_cmd_t c;
    c.joint    = j;
    c.torque   = TORQ_W'(torque);
    c.drive_en = de;
    c.drive_wr = dw;
    c.vel      = ANG_W'(vel);
    c.acc      = ACC_W'(acc);
    c.echo     = ANG_W'(echo);
    c.echo_ok  = ev;
    return c;
  endfunction

  function automatic joint_sample_t make_sample(input logic [JOINT_W-1:0] j,
                                                input logic signed [ANG_W-1:0] t,
                                                input logic signed [ANG_W-1:0] m,
                                                input logic signed [ANG_W-1:0] v);
    joint_sample_t s;
    s.joint = j;
    s.tgt   = t;
    s.meas  = m;
    s.mvel  = v;
    return s;
  endfunction

  task automatic add_row(input row_kind_t kind, input joint_sample_t s, input joint_cmd_t want);
    stim_row_t r;
    r.kind    = kind;
    r.s       = s;
    r.want    = want;
    r.reg_sel = CFG_RATE;
    r.data    = '0;
    directed_rows.push_back(r);
  endtask

  task automatic add_write(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] d);
    stim_row_t r;
    r.kind    = ROW_WRITE;
    r.s       = '0;
    r.want    = '0;
    r.reg_sel = sel;
    r.data    = d;
    directed_rows.push_back(r);
  endtask

  // Mostly smooth trajectories with random content; some full-range noise,
  // some target jumps and some samples for the dropped joint index.
  function automatic joint_sample_t next_random_sample();
    joint_sample_t s;
    int            pick, step, err_span;
    pick = $urandom_range(0, 19);
    s.joint = JOINT_W'($urandom_range(0, JOINTS - 1));
    if (pick <= 1) begin
      if (pick == 1) s.joint = NO_JOINT;
      s.tgt  = $urandom();
      s.meas = $urandom();
      s.mvel = $urandom();
    end else begin
      step = int'($urandom_range(0, 8192)) - 4096;
      if (pick == 2) s.tgt = $urandom();
      else           s.tgt = trajectory_pos[s.joint] + step;
      case ($urandom_range(0, 2))
        0:       err_span = 16;
        1:       err_span = 1024;
        default: err_span = 65536;
      endcase
      s.meas = s.tgt + (int'($urandom_range(0, 2 * err_span)) - err_span);
      s.mvel = int'($urandom_range(0, 1 << 22)) - (1 << 21);
    end
    if (s.joint < JOINTS) trajectory_pos[s.joint] = s.tgt;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 40)
      $display("MISMATCH %s: got %0h want %0h at %0t ns", what, got, want, $time);
    mismatch_count++;
  endtask

  // Offer one sample and hold it until the transaction completes.
  task automatic offer_sample(input joint_sample_t s, input bit use_typed,
                              input joint_cmd_t typed);
    joint_cmd_t pred;
    smp.valid             <= 1'b1;
    smp.joint_index       <= s.joint;
    smp.target_angle      <= s.tgt;
    smp.measured_angle    <= s.meas;
    smp.measured_velocity <= s.mvel;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    if (s.joint < JOINTS) begin
      pred = predict_joint_command(s);
      cmd_expected_q.push_back(use_typed ? typed : pred);
    end
  endtask

  // Sender bursts: random length, random gap after each, sometimes none
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        smp.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Register writes are only legal with no sample in flight
  task automatic wait_idle();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (cmd_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One write transaction, then valid drops before the task returns
  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= sel;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (sel)
      CFG_RATE: rate_hz  = d[RATE_W-1:0];
      CFG_MODE: ctl_mode = d[MODE_W-1:0];
      CFG_EXEC: exec_on  = d[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Receiver: own stall pattern per phase, plus a long hold-off on request
  initial begin : sink_pacing
    int hold_left;
    int cyc;
    bit hold_seen;
    bit rdy;
    hold_left = 0;
    cyc       = 0;
    hold_seen = 1'b0;
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (sink_style)
          SINK_OPEN:     rdy = 1'b1;
          SINK_COIN:     rdy = ($urandom_range(0, 3) != 0);
          SINK_PERIODIC: rdy = ((cyc % 11) < 6);
          default:       rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
      res.ready <= rdy;
    end
  end

  // Each result transaction is compared with the oldest expectation
  always @(posedge clk) begin : result_check
    joint_cmd_t want;
    if (!rst && res.valid && res.ready) begin
      if (cmd_expected_q.size() == 0) begin
        report_mismatch("result with nothing expected", 64'(res.out_joint), 64'd0);
      end else begin
        want = cmd_expected_q.pop_front();
        if (res.out_joint !== want.joint)
          report_mismatch("out_joint", 64'(res.out_joint), 64'(want.joint));
        if (res.torque_command !== want.torque)
          report_mismatch("torque_command", 64'(res.torque_command), 64'(want.torque));
        if (res.drive_enable !== want.drive_en)
          report_mismatch("drive_enable", 64'(res.drive_enable), 64'(want.drive_en));
        if (res.drive_write !== want.drive_wr)
          report_mismatch("drive_write", 64'(res.drive_write), 64'(want.drive_wr));
        if (res.desired_velocity !== want.vel)
          report_mismatch("desired_velocity", 64'(res.desired_velocity), 64'(want.vel));
        if (res.desired_acceleration !== want.acc)
          report_mismatch("desired_acceleration", 64'(res.desired_acceleration),
                          64'(want.acc));
        if (res.position_echo !== want.echo)
          report_mismatch("position_echo", 64'(res.position_echo), 64'(want.echo));
        if (res.echo_valid !== want.echo_ok)
          report_mismatch("echo_valid", 64'(res.echo_valid), 64'(want.echo_ok));
      end
    end
  end

  initial begin : stimulus
    joint_sample_t s;
    joint_cmd_t    none;
    bit            prev_write;
    int            counted;
    logic [RATE_W-1:0] rate_pick;
    logic [MODE_W-1:0] mode_pick;
    bit                exec_pick;

    none = '0;
    rst  = 1'b1;
    smp.valid             = 1'b0;
    smp.joint_index       = '0;
    smp.target_angle      = '0;
    smp.measured_angle    = '0;
    smp.measured_velocity = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_RATE;
    cfg_ch.data  = '0;

    // power-on register values and empty joint history
    rate_hz  = RATE_RST;
    ctl_mode = MODE_RST;
    exec_on  = 1'b0;
    for (int j = 0; j < JOINTS; j++) begin
      last_setpoint[j]  = 0;
      last_vel_cmd[j]   = 0;
      joint_seen[j]     = 1'b0;
      trajectory_pos[j] = '0;
    end

    // Directed table. Typed rows: first sample of a joint (zero vel/acc),
    // torque clamped to either limit, and the simulation echo.
    // Mode "other" after reset: everything zero but the joint
    add_row(ROW_TYPED, make_sample(3'd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0),
            make_cmd(3'd0, 0, 0, 0, 0, 0, 0, 0));
    // out-of-range index: dropped, no result
    add_row(ROW_PREDICT, make_sample(NO_JOINT, 32'sh1234, 32'sh0, 32'sh0), none);
    // full-scale target swing: velocity and acceleration saturate low
    add_row(ROW_PREDICT, make_sample(3'd0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF), none);
    add_write(CFG_MODE, CFG_DATA_W'(MODE_OP));
    add_write(CFG_EXEC, 16'd1);
    add_row(ROW_TYPED, make_sample(3'd1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0),
            make_cmd(3'd1, 13107200, 1, 1, 0, 0, 0, 0));
    add_row(ROW_TYPED, make_sample(3'd2, 32'sh80000000, 32'sh7FFFFFFF, 32'sh0),
            make_cmd(3'd2, -5242880, 1, 1, 0, 0, 0, 0));
    add_row(ROW_TYPED, make_sample(3'd3, 32'sh0, 32'sh0, 32'sh0),
            make_cmd(3'd3, 0, 1, 1, 0, 0, 0, 0));
    add_row(ROW_PREDICT, make_sample(3'd4, 32'sh00010000, 32'sh0, 32'sh80000000), none);
    add_row(ROW_PREDICT, make_sample(3'd4, 32'sh00030000, 32'sh00028000, 32'sh00020000), none);
    // zero sample rate: no velocity or acceleration at all
    add_write(CFG_RATE, 16'd0);
    add_row(ROW_PREDICT, make_sample(3'd4, 32'sh7FFFFFFF, 32'sh0, 32'sh0), none);
    add_write(CFG_RATE, 16'hFFFF);
    add_row(ROW_PREDICT, make_sample(3'd5, 32'sh00001000, 32'sh0, 32'sh0), none);
    add_row(ROW_PREDICT, make_sample(3'd5, 32'sh7FFF0000, 32'sh7FFF0000, 32'sh0), none);
    add_row(ROW_PREDICT, make_sample(3'd5, 32'sh80000000, 32'sh80000000, 32'sh0), none);
    add_write(CFG_MODE, CFG_DATA_W'(MODE_SIM));
    add_row(ROW_TYPED, make_sample(3'd6, 32'sh12345678, 32'sh0, 32'sh0),
            make_cmd(3'd6, 0, 0, 1, 0, 0, 32'h12345678, 1));
    add_row(ROW_PREDICT, make_sample(3'd6, 32'sh80000000, 32'sh0, 32'sh7FFFFFFF), none);
    // unused mode code behaves like "other"
    add_write(CFG_MODE, CFG_DATA_W'(MODE_SPARE));
    add_row(ROW_PREDICT, make_sample(3'd0, 32'sh1, 32'sh0, 32'sh0), none);
    add_write(CFG_EXEC, 16'd0);
    add_write(CFG_RATE, 16'd1);
    add_row(ROW_PREDICT, make_sample(3'd1, 32'sh00020000, 32'sh00010000, 32'shFFFF0000), none);
    // operation mode without execute: no command at all
    add_write(CFG_MODE, CFG_DATA_W'(MODE_OP));
    add_row(ROW_PREDICT, make_sample(3'd2, 32'sh00000100, 32'sh00000080, 32'sh40), none);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    prev_write = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        if (!prev_write) wait_idle();
        write_reg(directed_rows[i].reg_sel, directed_rows[i].data);
      end else begin
        offer_sample(directed_rows[i].s, directed_rows[i].kind == ROW_TYPED,
                     directed_rows[i].want);
        pace();
      end
      prev_write = (directed_rows[i].kind == ROW_WRITE);
    end

    // Random phases, each under its own register setting; the receiver pattern rotates through
    // the four sink styles. Extremes of the rate and every mode code are visited, execute on and off.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin rate_pick = 16'd1000;  mode_pick = MODE_OP;    exec_pick = 1'b1; end
        1: begin rate_pick = 16'd1;     mode_pick = MODE_OP;    exec_pick = 1'b1; end
        2: begin rate_pick = 16'hFFFF;  mode_pick = MODE_SIM;   exec_pick = 1'b1; end
        3: begin
          rate_pick = RATE_W'($urandom());
          mode_pick = MODE_OP;
          exec_pick = 1'b1;
        end
        4: begin rate_pick = 16'd0;     mode_pick = MODE_SPARE; exec_pick = 1'b0; end
        5: begin
          rate_pick = RATE_W'($urandom_range(1, 4000));
          mode_pick = MODE_OP;
          exec_pick = 1'b1;
        end
        6: begin
          rate_pick = RATE_W'($urandom());
          mode_pick = MODE_IDLE;
          exec_pick = 1'b1;
        end
        default: begin rate_pick = 16'hFFFF; mode_pick = MODE_OP; exec_pick = 1'b0; end
      endcase
      wait_idle();
      sink_style <= sink_style_t'(phase % 4);
      write_reg(CFG_RATE, rate_pick);
      write_reg(CFG_MODE, CFG_DATA_W'(mode_pick));
      write_reg(CFG_EXEC, CFG_DATA_W'(exec_pick));

      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        s = next_random_sample();
        if (s.joint < JOINTS) counted++;
        // Long receiver hold-off while the sender keeps offering: the output
        // register fills and the block must stall its input.
        if (phase == 3 && counted == 60 && s.joint < JOINTS) hold_req <= ~hold_req;
        offer_sample(s, 1'b0, none);
        pace();
      end
    end

    smp.valid <= 1'b0;
    while (cmd_expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/jpd_pkg.sv
rtl/jpd_if.sv
rtl/joint_pd_torque_controller.sv
tb/sv/joint_pd_torque_controller_tb.sv
